### rtl/core/ntc_pkg.sv
// shared constants, register codes and reset values for the ntc temperature converter
// no dependencies; compile first
`timescale 1ns / 1ps

package ntc_pkg;

	localparam int ADC_BITS_DEF = 10;

	// fixed field widths
	localparam int SER_W  = 20;
	localparam int BETA_W = 15;
	localparam int TEMP_W = 16;
	localparam int T0_W   = 17;

	// fixed-point formats
	localparam int FRAC_BITS = 16;
	localparam int MANT_W    = 31;
	localparam int LN2_W     = 30;
	localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
	localparam int CENTI_W = 23;
	localparam logic [CENTI_W-1:0] CENTI_Q16 = 23'd6553600;
	localparam int KELVIN_OFFSET_CENTI = 27315;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADC_LOW   = 3'd0,
		CFG_ADC_HIGH  = 3'd1,
		CFG_SERIES    = 3'd2,
		CFG_NOMINAL   = 3'd3,
		CFG_BETA      = 3'd4,
		CFG_NOM_TEMP  = 3'd5,
		CFG_TEMP_FLOOR = 3'd6,
		CFG_TEMP_CEIL = 3'd7
	} cfg_reg_t;

	localparam logic [SER_W-1:0]         SERIES_RST  = 20'd10000;
	localparam logic [SER_W-1:0]         NOMINAL_RST = 20'd10000;
	localparam logic [BETA_W-1:0]        BETA_RST    = 15'd3950;
	localparam logic signed [TEMP_W-1:0] NOM_TEMP_RST = 16'sd2500;
	localparam logic signed [TEMP_W-1:0] FLOOR_RST   = -16'sd4000;
	localparam logic signed [TEMP_W-1:0] CEIL_RST    = 16'sd12500;

endpackage

### rtl/core/ntc_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
// standalone; used by ntc_adc_to_celsius
`timescale 1ns / 1ps

module ntc_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic          out_vld,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_o
);

	// numerator shifts out the top while quotient bits enter at the bottom
	logic [NW-1:0] nq_w   [NW+1];
	logic [SW-1:0] side_w [NW+1];
	logic          vld_w  [NW+1];
	logic [DW-1:0] rem_w  [NW];
	logic [DW-1:0] den_w  [NW];

	assign nq_w[0]   = num;
	assign side_w[0] = side_i;
	assign vld_w[0]  = in_vld;
	assign rem_w[0]  = '0;
	assign den_w[0]  = den;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          ge;
		logic [NW-1:0] nq_s;
		logic [SW-1:0] side_s;
		logic          vld_s;

		assign trial = {rem_w[k], nq_w[k][NW-1]};
		assign ge    = trial >= {1'b0, den_w[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (en) begin
				vld_s <= vld_w[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s   <= {nq_w[k][NW-2:0], ge};
				side_s <= side_w[k];
			end
		end

		assign nq_w[k+1]   = nq_s;
		assign side_w[k+1] = side_s;
		assign vld_w[k+1]  = vld_s;

		if (k < NW - 1) begin : g_carry
			logic [DW:0]   diff;
			logic [DW-1:0] rem_s;
			logic [DW-1:0] den_s;

			assign diff = trial - {1'b0, den_w[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s <= ge ? diff[DW-1:0] : trial[DW-1:0];
					den_s <= den_w[k];
				end
			end

			assign rem_w[k+1] = rem_s;
			assign den_w[k+1] = den_s;
		end
	end

	assign out_vld = vld_w[NW];
	assign quo     = nq_w[NW];
	assign side_o  = side_w[NW];

endmodule

### rtl/core/ntc_log.sv
// pipelined natural log of a ratio with 16 fraction bits (q30.16 at the default RW): leading-one search, normalize,
// sixteen squaring stages, scale by ln 2; uses ntc_pkg
`timescale 1ns / 1ps

module ntc_log #(
	parameter int RW = 46
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  logic ok_i,
	input  logic [RW-1:0] ratio,
	output logic out_vld,
	output logic ok_o,
	output logic signed [$clog2(RW)+ntc_pkg::FRAC_BITS:0] ln_val
);

	import ntc_pkg::*;

	localparam int PW  = $clog2(RW);
	localparam int LW  = PW + FRAC_BITS + 1;
	localparam int NCH = (RW + 7) / 8;
	localparam int PDW = LW + LN2_W;

	// chunk search
	logic [NCH*8-1:0] rpad;
	logic [NCH-1:0]   any_c;
	logic [2:0]       pos_c [NCH];
	logic [RW-1:0]    ratio_s1;
	logic [NCH-1:0]   any_s1;
	logic [2:0]       pos_s1 [NCH];
	logic             vld_s1, ok_s1;

	assign rpad = (NCH*8)'(ratio);

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			any_c[c] = |rpad[c*8 +: 8];
			pos_c[c] = 3'd0;
			for (int j = 0; j < 8; j++) begin
				if (rpad[c*8+j]) begin
					pos_c[c] = 3'(j);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s1 <= ratio;
			any_s1   <= any_c;
			pos_s1   <= pos_c;
			ok_s1    <= ok_i;
		end
	end

	// pick the highest nonzero chunk
	logic [PW-1:0] p_c;
	logic [RW-1:0] ratio_s2;
	logic [PW-1:0] p_s2;
	logic          vld_s2, ok_s2;

	always_comb begin
		p_c = '0;
		for (int c = 0; c < NCH; c++) begin
			if (any_s1[c]) begin
				p_c = PW'(c*8) + PW'(pos_s1[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s2 <= ratio_s1;
			p_s2     <= p_c;
			ok_s2    <= ok_s1 && (|any_s1);
		end
	end

	// normalize mantissa to q1.30
	logic [RW+MANT_W-2:0] sh;
	logic [MANT_W-1:0]    m_w    [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] frac_w [FRAC_BITS+1];
	logic [PW-1:0]        p_w    [FRAC_BITS+1];
	logic                 vld_w  [FRAC_BITS+1];
	logic                 ok_w   [FRAC_BITS+1];
	logic [MANT_W-1:0]    m_s3;
	logic [PW-1:0]        p_s3;
	logic                 vld_s3, ok_s3;

	assign sh = {ratio_s2, (MANT_W-1)'(0)} >> p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3  <= sh[MANT_W-1:0];
			p_s3  <= p_s2;
			ok_s3 <= ok_s2;
		end
	end

	assign m_w[0]    = m_s3;
	assign frac_w[0] = '0;
	assign p_w[0]    = p_s3;
	assign vld_w[0]  = vld_s3;
	assign ok_w[0]   = ok_s3;

	// one fraction bit per squaring
	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_sq
		logic [2*MANT_W-1:0]  sq;
		logic [MANT_W:0]      top;
		logic [MANT_W-1:0]    m_s;
		logic [FRAC_BITS-1:0] frac_s;
		logic [PW-1:0]        p_s;
		logic                 vld_s, ok_s;

		assign sq  = (2*MANT_W)'(m_w[k]) * (2*MANT_W)'(m_w[k]);
		assign top = sq[2*MANT_W-1:MANT_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (en) begin
				vld_s <= vld_w[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s    <= top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];
				frac_s <= {frac_w[k][FRAC_BITS-2:0], top[MANT_W]};
				p_s    <= p_w[k];
				ok_s   <= ok_w[k];
			end
		end

		assign m_w[k+1]    = m_s;
		assign frac_w[k+1] = frac_s;
		assign p_w[k+1]    = p_s;
		assign vld_w[k+1]  = vld_s;
		assign ok_w[k+1]   = ok_s;
	end

	// log2 in signed q6.16 (at the default RW) to magnitude and sign
	logic signed [PW:0]   pm16;
	logic signed [LW-1:0] x;
	logic [LW-1:0]        ax_sa;
	logic                 neg_sa, vld_sa, ok_sa;

	assign pm16 = $signed({1'b0, p_w[FRAC_BITS]}) - $signed((PW+1)'(FRAC_BITS));
	assign x    = {pm16, frac_w[FRAC_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
		end else if (en) begin
			vld_sa <= vld_w[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_sa  <= x[LW-1] ? LW'(-x) : LW'(x);
			neg_sa <= x[LW-1];
			ok_sa  <= ok_w[FRAC_BITS];
		end
	end

	// times ln 2 in q30
	logic [PDW-1:0] prod_sb;
	logic           neg_sb, vld_sb, ok_sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sb <= 1'b0;
		end else if (en) begin
			vld_sb <= vld_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sb <= PDW'(ax_sa) * PDW'(LN2_Q30);
			neg_sb  <= neg_sa;
			ok_sb   <= ok_sa;
		end
	end

	// round half away from zero
	logic [PDW-1:0] rnd;
	logic [LW-1:0]  mag;
	logic signed [LW-1:0] ln_sc;
	logic           vld_sc, ok_sc;

	assign rnd = prod_sb + (PDW'(1) << (LN2_W - 1));
	assign mag = rnd[PDW-1:LN2_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc <= 1'b0;
		end else if (en) begin
			vld_sc <= vld_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ln_sc <= neg_sb ? -$signed(mag) : $signed(mag);
			ok_sc <= ok_sb;
		end
	end

	assign out_vld = vld_sc;
	assign ok_o    = ok_sc;
	assign ln_val  = ln_sc;

endmodule

### rtl/core/ntc_adc_to_celsius.sv
// top level of the ntc thermistor adc-to-celsius converter (beta equation)
// uses ntc_pkg, ntc_div, ntc_log
`timescale 1ns / 1ps

// Converts one ADC code from an NTC divider into a temperature in hundredths of a degree
// Celsius. The pipeline takes one sample in every clock cycle while not stalled and returns
// results in order; most of its depth lies in the two bit-per-stage dividers (resistance
// ratio and beta equation) and the sixteen squaring stages of the logarithm. A stall on
// the result side freezes the whole pipeline, so adc_stall follows temp_stall whenever a
// result is waiting. Codes at a rail, a zero nominal resistance, a zero ratio or a zero
// divisor give reading_valid low with temperature 0. The user must write configuration over
// the cfg port (always ready) only while no sample is in flight; the block does not enforce it.

module ntc_adc_to_celsius #(
	parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	// sample in
	input  logic                adc_valid,
	output logic                adc_stall,
	input  logic [ADC_BITS-1:0] adc_code,

	// result out
	output logic                                temp_valid,
	input  logic                                temp_stall,
	output logic signed [ntc_pkg::TEMP_W-1:0]   temperature_centi,
	output logic                                reading_valid,

	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ntc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import ntc_pkg::*;

	localparam logic [ADC_BITS-1:0] FULL_CODE = {ADC_BITS{1'b1}};
	localparam int NUM_W   = SER_W + ADC_BITS;
	localparam int DEN_W   = SER_W + ADC_BITS;
	localparam int RATIO_W = NUM_W + FRAC_BITS;
	localparam int PW      = $clog2(RATIO_W);
	localparam int LW      = PW + FRAC_BITS + 1;
	localparam int BT_W    = BETA_W + 1 + T0_W;
	localparam int TNUM_W  = BT_W + CENTI_W + 1;
	localparam int LT_W    = LW + T0_W;
	localparam int BC_W    = BETA_W + CENTI_W;
	localparam int TDEN_W  = ((LT_W > BC_W + 1) ? LT_W : BC_W + 1) + 1;
	localparam int UN_W    = TNUM_W + 1;
	localparam int QS_W    = UN_W + 1;
	localparam int TK_W    = QS_W + 1;

	// pipeline advances unless a finished result is held back
	logic adv;
	assign adv       = !temp_valid || !temp_stall;
	assign adc_stall = !adv;

	// ---------------------------------------------------------------- configuration
	logic [ADC_BITS-1:0]      adc_low_q, adc_high_q;
	logic [SER_W-1:0]         series_q, nominal_q;
	logic [BETA_W-1:0]        beta_q;
	logic signed [TEMP_W-1:0] nom_temp_q, floor_q, ceil_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_low_q  <= '0;
			adc_high_q <= FULL_CODE - ADC_BITS'(1);
			series_q   <= SERIES_RST;
			nominal_q  <= NOMINAL_RST;
			beta_q     <= BETA_RST;
			nom_temp_q <= NOM_TEMP_RST;
			floor_q    <= FLOOR_RST;
			ceil_q     <= CEIL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ADC_LOW:    adc_low_q  <= cfg_data[ADC_BITS-1:0];
				CFG_ADC_HIGH:   adc_high_q <= cfg_data[ADC_BITS-1:0];
				CFG_SERIES:     series_q   <= cfg_data[SER_W-1:0];
				CFG_NOMINAL:    nominal_q  <= cfg_data[SER_W-1:0];
				CFG_BETA:       beta_q     <= cfg_data[BETA_W-1:0];
				CFG_NOM_TEMP:   nom_temp_q <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_FLOOR: floor_q    <= cfg_data[TEMP_W-1:0];
				CFG_TEMP_CEIL:  ceil_q     <= cfg_data[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- s1: code window
	// low bound wins for codes below it; with an inverted window all other codes get the high bound
	logic [ADC_BITS-1:0] code_c;
	logic [ADC_BITS-1:0] code_s1;
	logic                ok_s1, vld_s1;

	always_comb begin
		if (adc_code < adc_low_q) begin
			code_c = adc_low_q;
		end else if (adc_code > adc_high_q) begin
			code_c = adc_high_q;
		end else begin
			code_c = adc_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= adc_valid;
		end
	end

	// a rail code or zero nominal resistance can never convert
	always_ff @(posedge clk) begin
		if (adv) begin
			code_s1 <= code_c;
			ok_s1   <= (code_c != '0) && (code_c != FULL_CODE) && (nominal_q != '0);
		end
	end

	// ---------------------------------------------------------------- s2: divider products
	logic [NUM_W-1:0] num_s2;
	logic [DEN_W-1:0] den_s2;
	logic             ok_s2, vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= NUM_W'(series_q) * NUM_W'(code_s1);
			den_s2 <= DEN_W'(nominal_q) * DEN_W'(FULL_CODE - code_s1);
			ok_s2  <= ok_s1;
		end
	end

	// ---------------------------------------------------------------- resistance ratio, q30.16
	logic               rdiv_vld;
	logic [RATIO_W-1:0] ratio;
	logic               rdiv_ok;

	ntc_div #(
		.NW (RATIO_W),
		.DW (DEN_W),
		.SW (1)
	) u_ratio_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s2),
		.num     ({num_s2, FRAC_BITS'(0)}),
		.den     (den_s2),
		.side_i  (ok_s2),
		.out_vld (rdiv_vld),
		.quo     (ratio),
		.side_o  (rdiv_ok)
	);

	// ---------------------------------------------------------------- ln of the ratio
	logic               log_vld, log_ok;
	logic signed [LW-1:0] ln_q16;

	// a zero ratio has no leading one and drops ok inside the log unit
	ntc_log #(
		.RW (RATIO_W)
	) u_log (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (rdiv_vld),
		.ok_i    (rdiv_ok),
		.ratio   (ratio),
		.out_vld (log_vld),
		.ok_o    (log_ok),
		.ln_val  (ln_q16)
	);

	// ---------------------------------------------------------------- s3: beta equation products
	// t0 in centi-kelvin
	logic signed [T0_W-1:0] t0c;
	logic signed [BT_W-1:0] beta_bt, t0c_bt;
	logic signed [LT_W-1:0] ln_lt, t0c_lt;
	logic signed [BT_W-1:0] bt_s3;
	logic signed [LT_W-1:0] lt_s3;
	logic [BC_W-1:0]        bc_s3;
	logic                   ok_s3, vld_s3;

	assign t0c     = T0_W'(nom_temp_q) + T0_W'(KELVIN_OFFSET_CENTI);
	assign beta_bt = $signed(BT_W'(beta_q));
	assign t0c_bt  = BT_W'(t0c);
	assign ln_lt   = LT_W'(ln_q16);
	assign t0c_lt  = LT_W'(t0c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= log_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bt_s3 <= beta_bt * t0c_bt;
			lt_s3 <= ln_lt * t0c_lt;
			bc_s3 <= BC_W'(beta_q) * BC_W'(CENTI_Q16);
			ok_s3 <= log_ok;
		end
	end

	// ---------------------------------------------------------------- s4: numerator and divisor
	logic signed [TNUM_W-1:0] tnum_s4;
	logic signed [TDEN_W-1:0] tden_s4;
	logic                     ok_s4, vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tnum_s4 <= TNUM_W'(bt_s3) * $signed(TNUM_W'(CENTI_Q16));
			tden_s4 <= TDEN_W'(lt_s3) + $signed(TDEN_W'(bc_s3));
			ok_s4   <= ok_s3;
		end
	end

	// ---------------------------------------------------------------- s5: magnitudes and sign
	logic [TNUM_W-1:0] an_s5;
	logic [TDEN_W-1:0] ad_s5;
	logic              neg_s5, ok_s5, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	// zero divisor means infinite temperature
	always_ff @(posedge clk) begin
		if (adv) begin
			an_s5  <= tnum_s4[TNUM_W-1] ? TNUM_W'(-tnum_s4) : TNUM_W'(tnum_s4);
			ad_s5  <= tden_s4[TDEN_W-1] ? TDEN_W'(-tden_s4) : TDEN_W'(tden_s4);
			neg_s5 <= tnum_s4[TNUM_W-1] ^ tden_s4[TDEN_W-1];
			ok_s5  <= ok_s4 && (tden_s4 != '0);
		end
	end

	// ---------------------------------------------------------------- s6: rounding bias
	logic [UN_W-1:0]   un_s6;
	logic [TDEN_W-1:0] ad_s6;
	logic              neg_s6, ok_s6, vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			un_s6  <= UN_W'(an_s5) + UN_W'(ad_s5 >> 1);
			ad_s6  <= ad_s5;
			neg_s6 <= neg_s5;
			ok_s6  <= ok_s5;
		end
	end

	// ---------------------------------------------------------------- kelvin quotient
	logic            tdiv_vld;
	logic [UN_W-1:0] tq;
	logic [1:0]      tdiv_side;

	ntc_div #(
		.NW (UN_W),
		.DW (TDEN_W),
		.SW (2)
	) u_temp_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s6),
		.num     (un_s6),
		.den     (ad_s6),
		.side_i  ({neg_s6, ok_s6}),
		.out_vld (tdiv_vld),
		.quo     (tq),
		.side_o  (tdiv_side)
	);

	// ---------------------------------------------------------------- s7: apply sign
	logic signed [QS_W-1:0] qs_s7;
	logic                   ok_s7, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= tdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qs_s7 <= tdiv_side[1] ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
			ok_s7 <= tdiv_side[0];
		end
	end

	// ---------------------------------------------------------------- s8: to celsius
	logic signed [TK_W-1:0] tc_s8;
	logic                   ok_s8, vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tc_s8 <= TK_W'(qs_s7) - TK_W'(KELVIN_OFFSET_CENTI);
			ok_s8 <= ok_s7;
		end
	end

	// ---------------------------------------------------------------- output register
	// when the limits are inverted, readings below the floor give the floor, others the ceiling
	logic signed [TK_W-1:0] floor_x, ceil_x, tclamp;
	logic                   out_vld_q, out_ok_q;
	logic signed [TEMP_W-1:0] out_temp_q;

	assign floor_x = TK_W'(floor_q);
	assign ceil_x  = TK_W'(ceil_q);

	always_comb begin
		if (tc_s8 < floor_x) begin
			tclamp = floor_x;
		end else if (tc_s8 > ceil_x) begin
			tclamp = ceil_x;
		end else begin
			tclamp = tc_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_temp_q <= ok_s8 ? tclamp[TEMP_W-1:0] : '0;
			out_ok_q   <= ok_s8;
		end
	end

	assign temp_valid        = out_vld_q;
	assign temperature_centi = out_temp_q;
	assign reading_valid     = out_ok_q;

`ifndef SYNTH
	// a rejected reading always carries zero temperature
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		temp_valid && !reading_valid |-> temperature_centi == '0)
		else $error("invalid reading with nonzero temperature");

	// a fresh valid reading lies within ordered limits
	a_within_limits: assert property (@(posedge clk) disable iff (!arst_n)
		temp_valid && reading_valid && $past(adv) && $stable(floor_q) && $stable(ceil_q)
		&& (floor_q <= ceil_q)
		|-> (temperature_centi >= floor_q) && (temperature_centi <= ceil_q))
		else $error("temperature outside configured limits");
`endif

endmodule
